/* src/pmsq_pkg.sv */
// Shared types, constants and quantizing functions for the pixel model
// select and quantize block. No dependencies.
`default_nettype none

package pmsq_pkg;

  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 22;

  localparam logic [CFG_INDEX_W-1:0] REG_RMS_START  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIO_START = 1'd1;

  localparam logic [21:0] RMS_LIMIT_RESET  = 22'd2560000;
  localparam logic [7:0]  PRIO_LIMIT_RESET = 8'd100;

  localparam logic [7:0]         PCT_NODATA     = 8'hFF;
  localparam logic [7:0]         RMS_NODATA     = 8'hFF;
  localparam logic [15:0]        GRAIN_NODATA   = 16'hFFFF;
  localparam logic [21:0]        RMS_SAT_Q8     = 22'd65280;
  localparam logic signed [19:0] GRAIN_NODATA_Q4 = -20'sd159984;
  localparam logic signed [19:0] GRAIN_MAX_Q4   = 20'sd25600;
  localparam logic [15:0]        GRAIN_MAX_CODE = 16'd1600;
  localparam logic signed [15:0] FRAC_ONE_Q12   = 16'sd4096;
  localparam logic [7:0]         PCT_MAX        = 8'd100;

  typedef struct packed {
    logic signed [15:0] snow_fraction;
    logic signed [15:0] veg_fraction;
    logic signed [15:0] rock_fraction;
    logic signed [15:0] other_fraction;
    logic signed [15:0] shade_fraction;
    logic signed [19:0] grain_microns;
    logic [21:0]        fit_error;
    logic               model_ok;
    logic [7:0]         model_priority;
    logic               first_model;
    logic               last_model;
  } item_t;

  typedef struct packed {
    logic signed [15:0] snow;
    logic signed [15:0] veg;
    logic signed [15:0] rock;
    logic signed [15:0] other;
    logic signed [15:0] shade;
    logic signed [19:0] grain;
    logic [21:0]        rms;
    logic               found;
  } winner_t;

  localparam int unsigned WINNER_W = $bits(winner_t);

  typedef struct packed {
    logic        we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  function automatic logic [7:0] frac_to_pct(input logic signed [15:0] v);
    logic [22:0] t;
    logic [22:0] r;
    logic [7:0]  pct;
    begin
      t = 23'(v[14:0]) * 23'd100;
      r = t + 23'd2048;
      if (v <= 16'sd0) begin
        pct = 8'd0;
      end else if (v >= FRAC_ONE_Q12) begin
        pct = PCT_MAX;
      end else begin
        pct = r[19:12];
      end
      return pct;
    end
  endfunction

  function automatic logic [7:0] rms_to_code(input logic [21:0] rms);
    logic [21:0] r;
    logic [7:0]  code;
    begin
      r = rms + 22'd128;
      if (rms >= RMS_SAT_Q8) begin
        code = RMS_NODATA;
      end else begin
        code = r[15:8];
      end
      return code;
    end
  endfunction

  function automatic logic [15:0] grain_to_code(input logic signed [19:0] g);
    logic [15:0] r;
    logic [15:0] code;
    begin
      r = 16'(g[14:0]) + 16'd8;
      if (g <= GRAIN_NODATA_Q4) begin
        code = GRAIN_NODATA;
      end else if (g <= 20'sd0) begin
        code = 16'd0;
      end else if (g >= GRAIN_MAX_Q4) begin
        code = GRAIN_MAX_CODE;
      end else begin
        code = {4'd0, r[15:4]};
      end
      return code;
    end
  endfunction

endpackage

`default_nettype wire

/* src/pmsq_select.sv */
// Front part: holds the limit registers and the running best of the current
// pixel, and pushes the winner record on the last model. Uses pmsq_pkg.
`default_nettype none

module pmsq_select (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pmsq_pkg::cfg_write_t cfg,
  input  wire logic                fire,
  input  wire pmsq_pkg::item_t     item,
  output logic                     push,
  output pmsq_pkg::winner_t        winner
);

  logic [21:0] rms_limit;
  logic [7:0]  prio_limit;
  pmsq_pkg::winner_t best;
  logic [7:0]  best_priority;

  pmsq_pkg::winner_t best_next;
  pmsq_pkg::winner_t best_reset;
  pmsq_pkg::winner_t base;
  logic [7:0]  base_priority;
  logic [7:0]  best_priority_next;
  logic        take;

  always_comb begin
    best_reset     = '0;
    best_reset.rms = pmsq_pkg::RMS_LIMIT_RESET;
  end

  always_comb begin
    if (item.first_model) begin
      base          = '0;
      base.rms      = rms_limit;
      base_priority = prio_limit;
    end else begin
      base          = best;
      base_priority = best_priority;
    end
    take = item.model_ok && (item.fit_error < base.rms) &&
           (item.model_priority < base_priority);
    best_next          = base;
    best_priority_next = base_priority;
    if (take) begin
      best_next.snow     = item.snow_fraction;
      best_next.veg      = item.veg_fraction;
      best_next.rock     = item.rock_fraction;
      best_next.other    = item.other_fraction;
      best_next.shade    = item.shade_fraction;
      best_next.grain    = item.grain_microns;
      best_next.rms      = item.fit_error;
      best_next.found    = 1'b1;
      best_priority_next = item.model_priority;
    end
  end

  assign push   = fire && item.last_model;
  assign winner = best_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rms_limit  <= pmsq_pkg::RMS_LIMIT_RESET;
      prio_limit <= pmsq_pkg::PRIO_LIMIT_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        pmsq_pkg::REG_RMS_START:  rms_limit  <= cfg.data;
        pmsq_pkg::REG_PRIO_START: prio_limit <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best          <= best_reset;
      best_priority <= pmsq_pkg::PRIO_LIMIT_RESET;
    end else if (fire) begin
      best          <= best_next;
      best_priority <= best_priority_next;
    end
  end

endmodule

`default_nettype wire

/* src/pmsq_queue.sv */
// Short queue of winner records between the front and back parts.
// Uses pmsq_pkg for the record width.
`default_nettype none

module pmsq_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [pmsq_pkg::WINNER_W-1:0] din,
  input  wire logic                       pop,
  output logic [pmsq_pkg::WINNER_W-1:0]   dout,
  output logic                            full,
  output logic                            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [pmsq_pkg::WINNER_W-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/pmsq_quant.sv */
// Back part: unless the output is stalled, quantizes one winner record a cycle into the output register.
// Uses pmsq_pkg for the record type and the conversion functions.
`default_nettype none

module pmsq_quant (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 avail,
  input  wire pmsq_pkg::winner_t    winner,
  output logic                      take,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [pmsq_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                      m_tuser
);

  logic [7:0]  snow_pct;
  logic [7:0]  veg_pct;
  logic [7:0]  rock_pct;
  logic [7:0]  other_pct;
  logic [7:0]  shade_pct;
  logic [7:0]  rms_code;
  logic [15:0] grain_code;
  logic [pmsq_pkg::OUT_TDATA_W-1:0] m_tdata_next;

  assign take = avail && (!m_tvalid || m_tready);

  always_comb begin
    if (winner.found) begin
      snow_pct  = pmsq_pkg::frac_to_pct(winner.snow);
      veg_pct   = pmsq_pkg::frac_to_pct(winner.veg);
      rock_pct  = pmsq_pkg::frac_to_pct(winner.rock);
      other_pct = pmsq_pkg::frac_to_pct(winner.other);
      shade_pct = pmsq_pkg::frac_to_pct(winner.shade);
      rms_code  = pmsq_pkg::rms_to_code(winner.rms);
      if (snow_pct == 8'd0) begin
        grain_code = pmsq_pkg::GRAIN_NODATA;
      end else begin
        grain_code = pmsq_pkg::grain_to_code(winner.grain);
      end
    end else begin
      snow_pct   = pmsq_pkg::PCT_NODATA;
      veg_pct    = pmsq_pkg::PCT_NODATA;
      rock_pct   = pmsq_pkg::PCT_NODATA;
      other_pct  = pmsq_pkg::PCT_NODATA;
      shade_pct  = pmsq_pkg::PCT_NODATA;
      rms_code   = pmsq_pkg::RMS_NODATA;
      grain_code = pmsq_pkg::GRAIN_NODATA;
    end
    m_tdata_next = {grain_code, rms_code, shade_pct, other_pct, rock_pct, veg_pct, snow_pct};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= m_tdata_next;
      m_tuser <= winner.found;
    end
  end

endmodule

`default_nettype wire

/* src/pixel_model_select_quantize_top.sv */
// A last-model winner record passes the result queue, then the output register.
// Throughput: one model request per cycle; the result queue of QUEUE_DEPTH entries
// lets the input keep running while the output is stalled, until the queue fills.
// Reset (rst, synchronous) empties the queue and output and restores the limit
// registers to 10000.0 rms and priority 100.
// Uses pmsq_pkg, pmsq_select, pmsq_queue and pmsq_quant.
`default_nettype none

module pixel_model_select_quantize_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  // snow_fraction, veg_fraction, rock_fraction, other_fraction, shade_fraction,
  // grain_microns, fit_error, model_priority, zero fill
  input  wire logic [pmsq_pkg::IN_TDATA_W-1:0] s_tdata,
  // model_ok, first_model
  input  wire logic [pmsq_pkg::IN_TUSER_W-1:0] s_tuser,
  input  wire logic s_tlast,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // snow_pct, veg_pct, rock_pct, other_pct, shade_pct, rms_code, grain_code
  output logic [pmsq_pkg::OUT_TDATA_W-1:0] m_tdata,
  // modeled
  output logic      m_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [pmsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pmsq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pmsq_pkg::item_t      item;
  pmsq_pkg::cfg_write_t cfg;
  pmsq_pkg::winner_t    push_rec;
  pmsq_pkg::winner_t    head_rec;
  logic [pmsq_pkg::WINNER_W-1:0] head_bits;
  logic fire;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign item.snow_fraction  = s_tdata[15:0];
  assign item.veg_fraction   = s_tdata[31:16];
  assign item.rock_fraction  = s_tdata[47:32];
  assign item.other_fraction = s_tdata[63:48];
  assign item.shade_fraction = s_tdata[79:64];
  assign item.grain_microns  = s_tdata[99:80];
  assign item.fit_error      = s_tdata[121:100];
  assign item.model_priority = s_tdata[129:122];
  assign item.model_ok       = s_tuser[0];
  assign item.first_model    = s_tuser[1];
  assign item.last_model     = s_tlast;

  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;
  assign head_rec = head_bits;

  pmsq_select u_select (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item),
    .push   (q_push),
    .winner (push_rec)
  );

  pmsq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_rec),
    .pop   (q_pop),
    .dout  (head_bits),
    .full  (q_full),
    .empty (q_empty)
  );

  pmsq_quant u_quant (
    .clk      (clk),
    .rst      (rst),
    .avail    (!q_empty),
    .winner   (head_rec),
    .take     (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("winner record pushed into a full queue");

  a_nodata_codes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == pmsq_pkg::PCT_NODATA &&
    m_tdata[47:40] == pmsq_pkg::RMS_NODATA && m_tdata[63:48] == pmsq_pkg::GRAIN_NODATA))
    else $error("result without a winner carries data codes");

  a_zero_snow_grain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && m_tdata[7:0] == 8'd0) |-> (m_tdata[63:48] == pmsq_pkg::GRAIN_NODATA))
    else $error("zero snow result carries a grain size");
`endif

endmodule

`default_nettype wire

/* dv/pmsq_result_checker.sv */
// Result checker for pixel_model_select_quantize_top. It follows the request,
// result and register channels, keeps its own running winner per pixel and
// compares each result field by field. Depends on pmsq_pkg.

module pmsq_result_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [pmsq_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic [pmsq_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  wire logic                             s_tlast,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [pmsq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             m_tuser,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [pmsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pmsq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    error_count,
  output int                                    pending,
  output int                                    results_seen,
  output int                                    winners_seen
);
  import pmsq_pkg::*;

  localparam int GRAIN_LSB = 80;
  localparam int ERR_LSB   = 100;
  localparam int PRIO_LSB  = 122;
  localparam int OK_BIT    = 0;
  localparam int FIRST_BIT = 1;

  typedef struct packed {
    logic [7:0]  snow;
    logic [7:0]  veg;
    logic [7:0]  rock;
    logic [7:0]  other;
    logic [7:0]  shade;
    logic [7:0]  rms;
    logic [15:0] grain;
    logic        modeled;
  } pixel_code_t;

  logic [21:0]        rms_start;
  logic [7:0]         prio_start;
  logic signed [15:0] best_frac [5];
  logic signed [19:0] best_grain;
  logic [21:0]        best_err;
  logic [7:0]         best_prio;
  logic               best_found;
  pixel_code_t        expected_codes [$];
  int                 fails = 0;
  int                 seen = 0;
  int                 won = 0;

  function automatic logic [7:0] percent_of(input logic signed [15:0] f);
    int t;
    t = int'(f) * 100 + 2048;
    if (f <= 0) return 8'd0;
    if (f >= FRAC_ONE_Q12) return PCT_MAX;
    return 8'(t / 4096);
  endfunction

  function automatic pixel_code_t code_winner();
    pixel_code_t c;
    c.modeled = best_found;
    if (!best_found) begin
      c.snow  = PCT_NODATA;
      c.veg   = PCT_NODATA;
      c.rock  = PCT_NODATA;
      c.other = PCT_NODATA;
      c.shade = PCT_NODATA;
      c.rms   = RMS_NODATA;
      c.grain = GRAIN_NODATA;
      return c;
    end
    c.snow  = percent_of(best_frac[0]);
    c.veg   = percent_of(best_frac[1]);
    c.rock  = percent_of(best_frac[2]);
    c.other = percent_of(best_frac[3]);
    c.shade = percent_of(best_frac[4]);
    if (best_err >= RMS_SAT_Q8) begin
      c.rms = 8'd255;
    end else begin
      c.rms = 8'((best_err + 22'd128) >> 8);
    end
    // Zero snow hides the grain size just like the grain nodata marker does.
    if (best_grain <= GRAIN_NODATA_Q4 || c.snow == 8'd0) begin
      c.grain = GRAIN_NODATA;
    end else if (best_grain <= 20'sd0) begin
      c.grain = 16'd0;
    end else if (best_grain >= GRAIN_MAX_Q4) begin
      c.grain = GRAIN_MAX_CODE;
    end else begin
      c.grain = 16'((int'(best_grain) + 8) >> 4);
    end
    return c;
  endfunction

  task automatic clear_winner();
    for (int i = 0; i < 5; i++) best_frac[i] = 16'sd0;
    best_grain = 20'sd0;
    best_err   = rms_start;
    best_prio  = prio_start;
    best_found = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    pixel_code_t want;
    if (rst) begin
      rms_start  = RMS_LIMIT_RESET;
      prio_start = PRIO_LIMIT_RESET;
      clear_winner();
      expected_codes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RMS_START: begin
            rms_start = cfg_data;
          end
          REG_PRIO_START: begin
            prio_start = cfg_data[7:0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[FIRST_BIT]) clear_winner();
        if (s_tuser[OK_BIT] && s_tdata[ERR_LSB +: 22] < best_err &&
            s_tdata[PRIO_LSB +: 8] < best_prio) begin
          for (int i = 0; i < 5; i++) best_frac[i] = s_tdata[16*i +: 16];
          best_grain = s_tdata[GRAIN_LSB +: 20];
          best_err   = s_tdata[ERR_LSB +: 22];
          best_prio  = s_tdata[PRIO_LSB +: 8];
          best_found = 1'b1;
        end
        if (s_tlast) expected_codes.push_back(code_winner());
      end
      if (m_tvalid && m_tready) begin
        if (expected_codes.size() == 0) begin
          $error("Result with no pixel pending: tdata %h, tuser %b", m_tdata, m_tuser);
          fails++;
        end else begin
          want = expected_codes.pop_front();
          check_field("snow_pct", want.snow, m_tdata[7:0]);
          check_field("veg_pct", want.veg, m_tdata[15:8]);
          check_field("rock_pct", want.rock, m_tdata[23:16]);
          check_field("other_pct", want.other, m_tdata[31:24]);
          check_field("shade_pct", want.shade, m_tdata[39:32]);
          check_field("rms_code", want.rms, m_tdata[47:40]);
          check_field("grain_code", want.grain, m_tdata[63:48]);
          check_field("modeled", want.modeled, m_tuser);
          seen++;
          if (want.modeled) won++;
        end
      end
    end
    error_count  <= fails;
    pending      <= expected_codes.size();
    results_seen <= seen;
    winners_seen <= won;
  end

endmodule

/* dv/tb_top.sv */
// Top of the pixel_model_select_quantize_top regression: clock, reset, request
// and register stimulus, result back-pressure, watchdog and verdict.
// Depends on pmsq_pkg, the block itself and pmsq_result_checker.

module tb_top;
  import pmsq_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 4;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   s_tlast;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          error_count;
  int          pending;
  int          results_seen;
  int          winners_seen;
  int          sent;
  bit          steady;
  logic [21:0] cur_rms;
  logic [7:0]  cur_prio;

  pixel_model_select_quantize_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pmsq_result_checker codes_check (
    .clk          (clk),
    .rst          (rst),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .s_tlast      (s_tlast),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .pending      (pending),
    .results_seen (results_seen),
    .winners_seen (winners_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Most gaps are short; a few are long enough to fill the result queue.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [15:0] rand_fraction();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'($urandom);
    if (r == 2) begin
      case ($urandom_range(0, 5))
        0: return 16'sd0;
        1: return FRAC_ONE_Q12;
        2: return 16'sd4095;
        3: return 16'sh8000;
        4: return 16'sd21;
        default: return 16'sd20;
      endcase
    end
    return 16'(int'($urandom_range(0, 4400)) - 150);
  endfunction

  function automatic logic signed [19:0] rand_grain();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 20'($urandom);
    if (r < 5) begin
      case ($urandom_range(0, 6))
        0: return GRAIN_NODATA_Q4;
        1: return GRAIN_NODATA_Q4 + 20'sd1;
        2: return 20'sd8;
        3: return 20'sd7;
        4: return GRAIN_MAX_Q4;
        5: return GRAIN_MAX_Q4 - 20'sd1;
        default: return 20'sd0;
      endcase
    end
    if (r < 7) return 20'(-int'($urandom_range(0, 524288)));
    return 20'(int'($urandom_range(0, 27000)) - 400);
  endfunction

  function automatic logic [21:0] rand_fit_error();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 22'($urandom);
    if (r < 5) begin
      case ($urandom_range(0, 6))
        0: return 22'd0;
        1: return 22'd127;
        2: return 22'd128;
        3: return RMS_SAT_Q8 - 22'd1;
        4: return RMS_SAT_Q8;
        5: return cur_rms - 22'd1;
        default: return cur_rms;
      endcase
    end
    if (r < 12) return 22'($urandom_range(0, 70000));
    return 22'($urandom_range(0, cur_rms));
  endfunction

  function automatic item_t random_model(input bit first, input bit last);
    item_t m;
    m.snow_fraction  = rand_fraction();
    m.veg_fraction   = rand_fraction();
    m.rock_fraction  = rand_fraction();
    m.other_fraction = rand_fraction();
    m.shade_fraction = rand_fraction();
    m.grain_microns  = rand_grain();
    m.fit_error      = rand_fit_error();
    m.model_ok       = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 9) < 2) begin
      m.model_priority = 8'($urandom);
    end else begin
      m.model_priority = 8'($urandom_range(0, cur_prio));
    end
    m.first_model = first;
    m.last_model  = last;
    return m;
  endfunction

  function automatic item_t mk(input int frac, input int grain, input int err, input bit ok,
                               input int prio, input bit first, input bit last);
    item_t m;
    m.snow_fraction  = 16'(frac);
    m.veg_fraction   = 16'(frac);
    m.rock_fraction  = 16'(frac);
    m.other_fraction = 16'(frac);
    m.shade_fraction = 16'(frac);
    m.grain_microns  = 20'(grain);
    m.fit_error      = 22'(err);
    m.model_ok       = ok;
    m.model_priority = 8'(prio);
    m.first_model    = first;
    m.last_model     = last;
    return m;
  endfunction

  task automatic send(input item_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'd0, m.model_priority, m.fit_error, m.grain_microns, m.shade_fraction,
                 m.other_fraction, m.rock_fraction, m.veg_fraction, m.snow_fraction};
    s_tuser  <= {m.first_model, m.model_ok};
    s_tlast  <= m.last_model;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Mostly well-formed pixels; some lose a mark or get random marks.
  task automatic send_pixel();
    int n;
    int kind;
    n    = $urandom_range(1, 6);
    kind = $urandom_range(0, 99);
    for (int k = 0; k < n; k++) begin
      if (kind < 4) begin
        send(random_model(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else begin
        send(random_model(k == 0 && kind >= 10, k == n - 1 && !(kind >= 10 && kind < 15)));
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic [21:0] rms, input logic [CFG_DATA_W-1:0] prio);
    write_reg(REG_RMS_START, rms);
    write_reg(REG_PRIO_START, prio);
    cfg_valid <= 1'b0;
    cur_rms  = rms;
    cur_prio = prio[7:0];
  endtask

  initial begin
    int burst;
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      burst = $urandom_range(1, 24);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Watchdog: no request accepted for %0d cycles.", IDLE_LIMIT);
    $display("pixel_model_select_quantize_top regression: fail");
    $finish;
  end

  initial begin
    item_t m;
    int    quota;
    int    target;
    rst       <= 1'b1;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    steady   = 1'b0;
    sent     = 0;
    cur_rms  = RMS_LIMIT_RESET;
    cur_prio = PRIO_LIMIT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, each losing condition, and both marks on one request.
    send(mk(4096, 25600, 0, 1, 0, 1, 1));
    send(mk(32767, 524287, 65280, 1, 99, 1, 1));
    send(mk(-32768, 800, 128, 1, 5, 1, 1));
    send(mk(2048, 800, 1000, 0, 5, 1, 1));
    send(mk(2048, 800, 1000, 1, 100, 1, 1));
    send(mk(2048, 800, 2560000, 1, 5, 1, 1));
    // A three-model pixel where the last model wins with the grain nodata marker.
    send(mk(1000, 16000, 5000, 1, 50, 1, 0));
    send(mk(3000, 160, 4000, 1, 60, 0, 0));
    send(mk(21, -159984, 127, 1, 40, 0, 1));
    // Without a first mark the previous winner carries over.
    send(mk(0, 0, 0, 0, 0, 0, 1));
    m = mk(20, 8, 65279, 1, 10, 1, 0);
    m.snow_fraction = 16'sd4095;
    send(m);
    send(mk(4097, 7, 65279, 1, 10, 0, 1));
    m = mk(1, -159983, 500, 1, 0, 1, 1);
    m.snow_fraction = FRAC_ONE_Q12;
    send(m);
    send(mk(100, -1, 0, 1, 0, 1, 1));
    while (sent < 320) send_pixel();

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          set_limits(22'h3FFFFF, 22'h3FFFFF);
          quota = 450;
        end
        1: begin
          set_limits(22'd0, 22'd0);
          quota = 100;
        end
        2: begin
          set_limits(22'($urandom_range(60000, 3000000)), {14'($urandom), 8'd0});
          quota = 350;
        end
        3: begin
          set_limits(22'd70000, {14'($urandom), 8'($urandom_range(1, 255))});
          quota = 450;
        end
        default: begin
          set_limits(RMS_LIMIT_RESET, {14'd0, PRIO_LIMIT_RESET});
          quota = 350;
        end
      endcase
      target = sent + quota;
      while (sent < target) begin
        steady = (p == 4) && (target - sent > quota / 2);
        send_pixel();
      end
      steady = 1'b0;
    end
    drain();

    $display("Covered %0d model requests under six limit settings, extremes included.", sent);
    $display("Compared %0d pixel results, %0d of them with a selected model.",
             results_seen, winners_seen);
    if (error_count == 0) begin
      $display("pixel_model_select_quantize_top regression: pass");
    end else begin
      $display("pixel_model_select_quantize_top regression: fail");
    end
    $finish;
  end

endmodule
